[rtl/ocwk_pkg.sv]
// package for the omni chassis wheel kinematics block
// types, fixed-point constants, cordic arctangent table; no dependencies
`default_nettype none
package ocwk_pkg;

  localparam int unsigned TrigIterations = 16;
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned QueueDepth     = 2;

  localparam logic signed [35:0] PiQ28     = 36'sd843314857;
  localparam logic signed [35:0] TwoPiQ28  = 36'sd1686629713;
  localparam logic signed [35:0] HalfPiQ28 = 36'sd421657428;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic signed [24:0] InvSqrt2  = 25'sd11863283;

  localparam logic [9:0]  RadiusReset = 10'd150;
  localparam logic [15:0] StepReset   = 16'd655;

  typedef enum logic [0:0] {
    CFG_RADIUS = 1'b0,
    CFG_STEP   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] move_direction;
    logic signed [15:0] spin_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] wheel_one_speed;
    logic signed [15:0] wheel_two_speed;
    logic signed [15:0] wheel_three_speed;
    logic signed [15:0] wheel_four_speed;
  } out_item_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] spin;
    logic signed [31:0] dir_angle;
    logic signed [31:0] head_angle;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG_SETUP,
    ST_TRIG_RUN,
    ST_TRIG_DONE,
    ST_VEL,
    ST_COEF,
    ST_MIX,
    ST_SCALE,
    ST_OUT
  } back_state_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0:  r = 34'sd843314856;
        5'd1:  r = 34'sd497837829;
        5'd2:  r = 34'sd263043836;
        5'd3:  r = 34'sd133525158;
        5'd4:  r = 34'sd67021686;
        5'd5:  r = 34'sd33543515;
        5'd6:  r = 34'sd16775850;
        5'd7:  r = 34'sd8388437;
        5'd8:  r = 34'sd4194282;
        5'd9:  r = 34'sd2097149;
        5'd10: r = 34'sd1048575;
        5'd11: r = 34'sd524287;
        5'd12: r = 34'sd262143;
        5'd13: r = 34'sd131071;
        5'd14: r = 34'sd65535;
        5'd15: r = 34'sd32767;
        5'd16: r = 34'sd16383;
        5'd17: r = 34'sd8191;
        5'd18: r = 34'sd4095;
        5'd19: r = 34'sd2047;
        5'd20: r = 34'sd1023;
        5'd21: r = 34'sd511;
        5'd22: r = 34'sd255;
        5'd23: r = 34'sd127;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // one pass of the bounded wrap into minus pi to pi
  function automatic logic signed [35:0] wrap_step(input logic signed [35:0] a);
    logic signed [35:0] r;
    begin
      r = a;
      if (a > PiQ28) r = a - TwoPiQ28;
      else if (a < -PiQ28) r = a + TwoPiQ28;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/omni_chassis_wheel_kinematics.sv]
// omni wheel kinematics: one command in flight in the back end, so the back end
// takes a new command only once it is through with the last; throughput is set
// by the shared cordic and mix multiplier
// a waiting result holds the back end in its scale step; a two-entry queue decouples the front
// synchronous reset: heading zero, radius 150, step 655, queue empty
// depends on ocwk_pkg, ocwk_front, ocwk_queue, ocwk_back
`default_nettype none
module omni_chassis_wheel_kinematics #(
  parameter int unsigned TRIG_ITERATIONS = ocwk_pkg::TrigIterations
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ocwk_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ocwk_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data
);
  logic [9:0]      chassis_radius;
  logic [15:0]     step_time;
  logic            push, full, q_valid, pop;
  ocwk_pkg::work_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      chassis_radius <= ocwk_pkg::RadiusReset;
      step_time      <= ocwk_pkg::StepReset;
    end else if (cfg_we) begin
      unique case (ocwk_pkg::cfg_idx_t'(cfg_index))
        ocwk_pkg::CFG_RADIUS: chassis_radius <= cfg_data[9:0];
        ocwk_pkg::CFG_STEP:   step_time      <= cfg_data;
        default: ;
      endcase
    end
  end

  ocwk_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .step_time,
    .push, .push_data, .queue_full(full)
  );

  ocwk_queue u_queue (
    .clk, .rst, .push, .push_data, .full,
    .pop_valid(q_valid), .pop, .pop_data
  );

  ocwk_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk, .rst, .work_valid(q_valid), .work_pop(pop), .work(pop_data),
    .chassis_radius, .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

[rtl/ocwk_front.sv]
// front end: accepts commands, integrates and wraps the heading, scales and wraps the direction
// depends on ocwk_pkg
`default_nettype none
module ocwk_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ocwk_pkg::in_item_t in_data,
  input  wire logic [15:0]        step_time,
  output logic                    push,
  output ocwk_pkg::work_t         push_data,
  input  wire logic               queue_full
);

  logic signed [31:0] heading;
  logic signed [35:0] h0, h1, h2, h3;
  logic signed [35:0] d0, d1, d2, d3;
  logic signed [32:0] step_prod;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    step_prod = $signed({1'b0, step_time}) * 33'(in_data.spin_rate);
    h0 = 36'(heading) + 36'(step_prod);
    h1 = ocwk_pkg::wrap_step(h0);
    h2 = ocwk_pkg::wrap_step(h1);
    h3 = ocwk_pkg::wrap_step(h2);
    d0 = 36'(in_data.move_direction) <<< 15;
    d1 = ocwk_pkg::wrap_step(d0);
    d2 = ocwk_pkg::wrap_step(d1);
    d3 = ocwk_pkg::wrap_step(d2);
    push_data.speed      = in_data.linear_speed;
    push_data.spin       = in_data.spin_rate;
    push_data.dir_angle  = d3[31:0];
    push_data.head_angle = h3[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0;
    end else if (push) begin
      heading <= h3[31:0];
    end
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    push |-> (h3 <= ocwk_pkg::PiQ28 && h3 >= -ocwk_pkg::PiQ28))
    else $error("heading left range");
  a_push_beat: assert property (@(posedge clk) disable iff (rst)
    push |-> (in_valid && in_ready)) else $error("push without an input beat");
  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    !push |=> (heading == $past(heading))) else $error("heading moved without a beat");

endmodule
`default_nettype wire

[rtl/ocwk_queue.sv]
// short fifo between front and back end
// depends on ocwk_pkg
`default_nettype none
module ocwk_queue #(
  parameter int unsigned DEPTH = ocwk_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ocwk_pkg::work_t  push_data,
  output logic                  full,
  output logic                  pop_valid,
  input  wire logic             pop,
  output ocwk_pkg::work_t       pop_data
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ocwk_pkg::work_t  mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !pop_valid)) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count out of range");
endmodule
`default_nettype wire

[rtl/ocwk_back.sv]
// back end: shared cordic for both angles, then the wheel mix on one multiplier
// depends on ocwk_pkg
`default_nettype none
module ocwk_back #(
  parameter int unsigned TRIG_ITERATIONS = ocwk_pkg::TrigIterations
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              work_valid,
  output logic                   work_pop,
  input  wire ocwk_pkg::work_t   work,
  input  wire logic [9:0]        chassis_radius,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ocwk_pkg::out_item_t    out_data
);
  localparam int unsigned Iters = (TRIG_ITERATIONS < ocwk_pkg::AtanEntries) ?
                                  TRIG_ITERATIONS : ocwk_pkg::AtanEntries;
  localparam logic signed [25:0] InvSqrt2Ext = 26'(ocwk_pkg::InvSqrt2);

  ocwk_pkg::back_state_t state, state_next;
  ocwk_pkg::work_t       cur;
  logic                  pass;      // 0: direction, 1: heading
  logic [4:0]            iter;
  logic signed [33:0]    cx, cy, cz;
  logic                  flip;
  logic signed [15:0]    sd, cd, sa, ca;
  logic [2:0]            step;
  logic signed [31:0]    vx, vy;
  logic signed [16:0]    cf [8];
  logic signed [48:0]    prod;
  logic signed [55:0]    sum [4];
  logic signed [15:0]    wres [4];
  logic signed [15:0]    q_x, q_y;
  logic signed [31:0]    ang;
  logic signed [31:0]    ang_adj;
  logic                  ang_flip;
  logic signed [33:0]    sx, sy;
  logic signed [55:0]    spin_term;

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v,
                                                input logic neg);
    logic signed [34:0] t;
    logic signed [18:0] r;
    logic signed [15:0] c;
    begin
      t = 35'(v) + 35'sd32768;
      r = t[34:16];
      if (r > 19'sd16384) c = 16'sd16384;
      else if (r < -19'sd16384) c = -16'sd16384;
      else c = r[15:0];
      return neg ? -c : c;
    end
  endfunction

  // scale by one over root two, negate, truncate toward zero from q44, saturate
  function automatic logic signed [15:0] sat_out(input logic signed [55:0] s);
    logic signed [35:0] f;
    logic signed [61:0] p;
    logic signed [61:0] mag;
    logic signed [17:0] t;
    logic signed [15:0] r;
    begin
      f = s[55:20];
      p = -(62'(f) * 62'(InvSqrt2Ext));
      mag = p[61] ? -p : p;
      t = 18'(mag >>> 44);
      if (p[61]) t = -t;
      if (t > 18'sd32767) r = 16'sd32767;
      else if (t < -18'sd32768) r = -16'sd32768;
      else r = t[15:0];
      return r;
    end
  endfunction

  always_comb begin
    ang = pass ? cur.head_angle : cur.dir_angle;
    ang_flip = 1'b0;
    ang_adj = ang;
    if (36'(ang) > ocwk_pkg::HalfPiQ28) begin
      ang_adj = 32'(36'(ang) - ocwk_pkg::PiQ28);
      ang_flip = 1'b1;
    end else if (36'(ang) < -ocwk_pkg::HalfPiQ28) begin
      ang_adj = 32'(36'(ang) + ocwk_pkg::PiQ28);
      ang_flip = 1'b1;
    end
    sx = cx >>> iter;
    sy = cy >>> iter;
    q_x = to_q14(cx, flip);
    q_y = to_q14(cy, flip);
    spin_term = 56'($signed({1'b0, chassis_radius}) * 27'(cur.spin)) <<< 28;
  end

  // coefficient pairs per wheel: (vx coef, vy coef)
  always_comb begin
    cf[0] = -17'(ca) - 17'(sa);  cf[1] = 17'(ca) - 17'(sa);
    cf[2] = 17'(sa) - 17'(ca);   cf[3] = -17'(sa) - 17'(ca);
    cf[4] = 17'(ca) - 17'(sa);   cf[5] = 17'(sa) + 17'(ca);
    cf[6] = 17'(ca) + 17'(sa);   cf[7] = 17'(sa) - 17'(ca);
    // one coefficient by one velocity part per cycle
    prod = cf[step] * (step[0] ? vy : vx);
  end

  always_comb begin
    state_next = state;
    work_pop   = 1'b0;
    unique case (state)
      ocwk_pkg::ST_IDLE:       if (work_valid) state_next = ocwk_pkg::ST_TRIG_SETUP;
      ocwk_pkg::ST_TRIG_SETUP: state_next = ocwk_pkg::ST_TRIG_RUN;
      ocwk_pkg::ST_TRIG_RUN:   if (iter == 5'(Iters - 1)) state_next = ocwk_pkg::ST_TRIG_DONE;
      ocwk_pkg::ST_TRIG_DONE:  state_next = pass ? ocwk_pkg::ST_VEL : ocwk_pkg::ST_TRIG_SETUP;
      ocwk_pkg::ST_VEL:        if (step[0]) state_next = ocwk_pkg::ST_COEF;
      ocwk_pkg::ST_COEF:       state_next = ocwk_pkg::ST_MIX;
      ocwk_pkg::ST_MIX:        if (step == 3'd7) state_next = ocwk_pkg::ST_SCALE;
      // wait here while the previous result still sits on the output
      ocwk_pkg::ST_SCALE: begin
        if (step == 3'd3 && !out_valid) state_next = ocwk_pkg::ST_OUT;
      end
      ocwk_pkg::ST_OUT: begin
        if (!out_valid) begin
          state_next = ocwk_pkg::ST_IDLE;
          work_pop   = 1'b1;
        end
      end
      default: state_next = ocwk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ocwk_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == ocwk_pkg::ST_OUT && !out_valid) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ocwk_pkg::ST_IDLE: begin
        cur  <= work;
        pass <= 1'b0;
      end
      ocwk_pkg::ST_TRIG_SETUP: begin
        cx   <= ocwk_pkg::GainQ30;
        cy   <= '0;
        cz   <= 34'(ang_adj) <<< 2;
        flip <= ang_flip;
        iter <= '0;
      end
      ocwk_pkg::ST_TRIG_RUN: begin
        if (!cz[33]) begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - ocwk_pkg::atan_q30(iter);
        end else begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + ocwk_pkg::atan_q30(iter);
        end
        iter <= iter + 5'd1;
      end
      ocwk_pkg::ST_TRIG_DONE: begin
        if (pass) begin
          ca <= q_x; sa <= q_y;
        end else begin
          cd <= q_x; sd <= q_y;
        end
        pass <= 1'b1;
        step <= '0;
      end
      ocwk_pkg::ST_VEL: begin
        if (!step[0]) vx <= cur.speed * cd;
        else          vy <= cur.speed * sd;
        step <= step + 3'd1;
      end
      ocwk_pkg::ST_COEF: begin
        for (int k = 0; k < 4; k++) sum[k] <= spin_term;
        step <= '0;
      end
      ocwk_pkg::ST_MIX: begin
        sum[step[2:1]] <= sum[step[2:1]] + 56'(prod);
        step <= step + 3'd1;
      end
      ocwk_pkg::ST_SCALE: begin
        if (!out_valid) begin
          wres[step[1:0]] <= sat_out(sum[step[1:0]]);
          step <= step + 3'd1;
        end
      end
      ocwk_pkg::ST_OUT: ;
      default: ;
    endcase
  end

  assign out_data.wheel_one_speed   = wres[0];
  assign out_data.wheel_two_speed   = wres[1];
  assign out_data.wheel_three_speed = wres[2];
  assign out_data.wheel_four_speed  = wres[3];

  a_pop_with_work: assert property (@(posedge clk) disable iff (rst)
    !(work_pop && !work_valid)) else $error("pop without work");
  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ocwk_pkg::ST_TRIG_RUN) |-> (iter < 5'(Iters))) else $error("cordic overran");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while waiting");
endmodule
`default_nettype wire
